// ===== sv/prs_pkg.sv =====
// shared types and codes of the packet ring store
`timescale 1ns / 1ps

package prs_pkg;

  // fixed field widths
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned CAP_W  = 16;
  localparam int unsigned BYTE_W = 8;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_COMMIT  = 2'd1,
    OP_DEQUEUE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_TOO_LARGE = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  // one result beat
  typedef struct packed {
    status_e             status;
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic [LEN_W-1:0]    packet_length;
    logic                last;
    logic [CNT_W-1:0]    queue_count;
    logic                queue_empty;
  } out_beat_t;

endpackage

// ===== sv/prs_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module prs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/packet_ring_store_top.sv =====
// packet ring store: slot ring of packets with append, commit and dequeue
`timescale 1ns / 1ps

// Input beats on the s_axis channel carry an operation in tuser: append puts
// data_byte into the pending packet, commit closes it and answers with one
// status beat, dequeue returns the oldest packet on the m_axis channel.
// Appends give no result, so a source may stream one byte per cycle while
// no result beat is held by a stalled receiver. A commit is answered in the
// cycle after it is accepted. A dequeue reads the slot length from the
// length ram, then streams the bytes out of the byte ram at one beat per
// cycle unless stalled, tlast on the final one; an error or zero-length
// answer is a single beat. A dequeue holds the block until its final byte
// has moved from the registered byte ram read into the output register.
// Every beat reports the packet count and empty flag after the operation.
// Reset clears the slot pointers and the pending packet; the rams need no
// clearing, since slot data is only read after it was written.
// When the receiver stalls, the output register holds its beat, no new
// input beat is taken, and an ongoing dequeue pauses without losing data.

module packet_ring_store_top #(
  parameter int unsigned SLOTS            = 8,
  parameter int unsigned MAX_PACKET_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // data_byte[7:0], capacity[23:8]
  input  logic [1:0]  s_axis_tuser_i,  // operation[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_byte[7:0], packet_length[14:8], queue_count[17:15], queue_empty[18]
  output logic [23:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o,  // status[1:0], byte_valid[2]
  output logic        m_axis_tlast_o
);

  import prs_pkg::*;

  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned DEPTH = SLOTS * MAX_PACKET_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PACKET_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_BYTES
  } state_e;

  state_e             state_q, state_d;
  logic [SW-1:0]      ws_q, ws_d, rs_q, rs_d, deq_slot_q, deq_slot_d;
  logic [LEN_W-1:0]   pend_len_q, pend_len_d;
  logic               pend_over_q, pend_over_d;
  logic [CAP_W-1:0]   cap_q, cap_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LEN_W-1:0]   rd_idx_q, rd_idx_d, out_idx_q, out_idx_d;
  logic               dv_q, dv_d;
  logic               m_valid_q, m_valid_d;
  out_beat_t          beat_q, beat_d;

  logic               out_free, s_fire, out_load;
  op_e                op;
  logic [BYTE_W-1:0]  in_byte;
  logic [CAP_W-1:0]   in_cap;
  logic [SW-1:0]      cnt_after;

  logic               byte_we, byte_re, len_we, len_re;
  logic [AW-1:0]      byte_waddr, byte_raddr;
  logic [BYTE_W-1:0]  byte_rdata;
  logic [LEN_W-1:0]   len_rdata;
  logic               last_byte;

  assign op       = op_e'(s_axis_tuser_i);
  assign in_byte  = s_axis_tdata_i[7:0];
  assign in_cap   = s_axis_tdata_i[23:8];
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;

  // ram addresses
  assign byte_waddr = AW'(ws_q * MAX_PACKET_BYTES) + AW'(pend_len_q);
  assign byte_raddr = AW'(deq_slot_q * MAX_PACKET_BYTES) + AW'(rd_idx_q);
  assign last_byte  = (out_idx_q + 1'b1) == len_q;

  // control and result selection
  always_comb begin
    state_d     = state_q;
    ws_d        = ws_q;
    rs_d        = rs_q;
    deq_slot_d  = deq_slot_q;
    pend_len_d  = pend_len_q;
    pend_over_d = pend_over_q;
    cap_d       = cap_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    out_idx_d   = out_idx_q;
    dv_d        = dv_q;
    byte_we     = 1'b0;
    byte_re     = 1'b0;
    len_we      = 1'b0;
    len_re      = 1'b0;
    out_load    = 1'b0;
    beat_d      = beat_q;
    beat_d.status     = STAT_OK;
    beat_d.out_byte   = '0;
    beat_d.byte_valid = 1'b0;
    beat_d.last       = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          case (op)
            OP_APPEND: begin
              if (pend_len_q < MAX_LEN) begin
                byte_we    = 1'b1;
                pend_len_d = pend_len_q + 1'b1;
              end else begin
                pend_over_d = 1'b1;
              end
            end
            OP_COMMIT: begin
              out_load = 1'b1;
              beat_d.packet_length = pend_len_q;
              if (pend_over_q) begin
                beat_d.status = STAT_TOO_LARGE;
              end else if (SW'(ws_q + 1'b1) == rs_q) begin
                beat_d.status = STAT_FULL;
              end else begin
                len_we = 1'b1;
                ws_d   = SW'(ws_q + 1'b1);
              end
              pend_len_d  = '0;
              pend_over_d = 1'b0;
            end
            OP_DEQUEUE: begin
              if (ws_q == rs_q) begin
                out_load = 1'b1;
                beat_d.status        = STAT_EMPTY;
                beat_d.packet_length = '0;
              end else begin
                len_re  = 1'b1;
                cap_d   = in_cap;
                state_d = S_LEN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LEN: begin
        len_d = len_rdata;
        if (out_free) begin
          if (cap_q < CAP_W'(len_rdata)) begin
            out_load = 1'b1;
            beat_d.status        = STAT_TOO_LARGE;
            beat_d.packet_length = len_rdata;
            state_d = S_IDLE;
          end else begin
            rs_d = SW'(rs_q + 1'b1);
            if (len_rdata == '0) begin
              out_load = 1'b1;
              beat_d.packet_length = '0;
              state_d = S_IDLE;
            end else begin
              deq_slot_d = rs_q;
              rd_idx_d   = '0;
              out_idx_d  = '0;
              dv_d       = 1'b0;
              state_d    = S_BYTES;
            end
          end
        end
      end
      S_BYTES: begin
        // move the held ram byte to the output, refill the ram stage
        out_load = dv_q && out_free;
        byte_re  = (rd_idx_q < len_q) && (!dv_q || out_load);
        if (byte_re) begin
          rd_idx_d = rd_idx_q + 1'b1;
          dv_d     = 1'b1;
        end else if (out_load) begin
          dv_d = 1'b0;
        end
        if (out_load) begin
          beat_d.out_byte      = byte_rdata;
          beat_d.byte_valid    = 1'b1;
          beat_d.packet_length = len_q;
          beat_d.last          = last_byte;
          out_idx_d = out_idx_q + 1'b1;
          if (last_byte) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // occupancy after this step
    cnt_after = SW'(ws_d - rs_d);
    beat_d.queue_count = CNT_W'(cnt_after);
    beat_d.queue_empty = (cnt_after == '0);

    // output register handshake
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ws_q        <= '0;
      rs_q        <= '0;
      pend_len_q  <= '0;
      pend_over_q <= 1'b0;
      rd_idx_q    <= '0;
      out_idx_q   <= '0;
      dv_q        <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ws_q        <= ws_d;
      rs_q        <= rs_d;
      pend_len_q  <= pend_len_d;
      pend_over_q <= pend_over_d;
      rd_idx_q    <= rd_idx_d;
      out_idx_q   <= out_idx_d;
      dv_q        <= dv_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    deq_slot_q <= deq_slot_d;
    cap_q      <= cap_d;
    len_q      <= len_d;
    if (out_load) begin
      beat_q <= beat_d;
    end
  end

  // packet bytes
  prs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (in_byte),
    .re_i    (byte_re),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  // slot lengths
  prs_ram #(
    .WIDTH (LEN_W),
    .DEPTH (SLOTS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (ws_q),
    .wdata_i (pend_len_q),
    .re_i    (len_re),
    .raddr_i (rs_q),
    .rdata_o (len_rdata)
  );

  // output ports
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'b0, beat_q.queue_empty, beat_q.queue_count,
                            beat_q.packet_length, beat_q.out_byte};
  assign m_axis_tuser_o  = {beat_q.byte_valid, beat_q.status};
  assign m_axis_tlast_o  = beat_q.last;

  // checks
  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && beat_q.byte_valid) |-> (beat_q.status == STAT_OK))
    else $error("data beat with error status");

  a_dv_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |-> (state_q == S_BYTES))
    else $error("ram byte held outside dequeue");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BYTES) |-> (rd_idx_q <= len_q && out_idx_q <= rd_idx_q))
    else $error("dequeue index out of range");

  a_commit_ans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && op == OP_COMMIT) |=> (m_valid_q && beat_q.last))
    else $error("commit without status beat");

endmodule

// ===== test/testbench.sv =====
// testbench of the packet ring store: directed table, random packets, scoreboard
`timescale 1ns / 1ps

module testbench;
  import prs_pkg::*;

  localparam int unsigned SLOTS     = 8;
  localparam int unsigned MAX_BYTES = 64;
  localparam int unsigned LIMIT     = 400000;
  localparam int unsigned N_RANDOM  = 170;

  // one row of the directed table
  typedef struct {
    op_e         op;
    logic [7:0]  data;
    logic [15:0] cap;
    int          reps;
    bit          typed;
    status_e     st;
    logic [6:0]  len;
    logic [2:0]  cnt;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [23:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // predictor copy of the store
  logic [7:0]  ring_bytes [SLOTS*MAX_BYTES];
  logic [6:0]  ring_len [SLOTS];
  logic [2:0]  wr_slot = '0;
  logic [2:0]  rd_slot = '0;
  logic [6:0]  pend_len = '0;
  logic        pend_over = 1'b0;

  out_beat_t   fresh_beats[$];
  out_beat_t   awaited_beats[$];
  dir_row_t    dir_tab[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned items_done = 0;
  bit          calm = 1'b0;

  packet_ring_store_top #(
    .SLOTS(SLOTS),
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_data),
    .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tuser_o(m_axis_tuser_o),
    .m_axis_tlast_o(m_axis_tlast_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stalls at random outside the calm stretch
  always @(posedge clk_i) begin
    m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 27);
  end

  // result beat with the count and empty flag after the step
  function automatic out_beat_t mk_beat(status_e st, logic [7:0] b, logic bv,
                                        logic [6:0] len, logic lst);
    out_beat_t r;
    r.status        = st;
    r.out_byte      = b;
    r.byte_valid    = bv;
    r.packet_length = len;
    r.last          = lst;
    r.queue_count   = wr_slot - rd_slot;
    r.queue_empty   = (wr_slot == rd_slot);
    return r;
  endfunction

  // single status beat as typed into the directed table
  function automatic out_beat_t typed_beat(status_e st, logic [6:0] len, logic [2:0] cnt);
    out_beat_t r;
    r = '0;
    r.status        = st;
    r.packet_length = len;
    r.last          = 1'b1;
    r.queue_count   = cnt;
    r.queue_empty   = (cnt == 3'd0);
    return r;
  endfunction

  // store behavior for one accepted beat, results go to fresh_beats
  function automatic void predict_store(op_e op, logic [7:0] d, logic [15:0] cap);
    logic [6:0] len;
    logic [2:0] slot;
    status_e    st;
    case (op)
      OP_APPEND: begin
        if (pend_len < 7'(MAX_BYTES)) begin
          ring_bytes[int'(wr_slot) * MAX_BYTES + int'(pend_len)] = d;
          pend_len = pend_len + 7'd1;
        end else begin
          pend_over = 1'b1;
        end
      end
      OP_COMMIT: begin
        len = pend_len;
        // too large wins over full
        if (pend_over) begin
          st = STAT_TOO_LARGE;
        end else if (3'(wr_slot + 3'd1) == rd_slot) begin
          st = STAT_FULL;
        end else begin
          ring_len[wr_slot] = len;
          wr_slot = wr_slot + 3'd1;
          st = STAT_OK;
        end
        pend_len  = '0;
        pend_over = 1'b0;
        fresh_beats.push_back(mk_beat(st, 8'd0, 1'b0, len, 1'b1));
      end
      OP_DEQUEUE: begin
        if (wr_slot == rd_slot) begin
          fresh_beats.push_back(mk_beat(STAT_EMPTY, 8'd0, 1'b0, 7'd0, 1'b1));
        end else begin
          slot = rd_slot;
          len  = ring_len[slot];
          if ({9'd0, len} > cap) begin
            // packet stays in place
            fresh_beats.push_back(mk_beat(STAT_TOO_LARGE, 8'd0, 1'b0, len, 1'b1));
          end else begin
            rd_slot = rd_slot + 3'd1;
            if (len == 7'd0) begin
              fresh_beats.push_back(mk_beat(STAT_OK, 8'd0, 1'b0, 7'd0, 1'b1));
            end else begin
              for (int i = 0; i < int'(len); i++) begin
                fresh_beats.push_back(mk_beat(STAT_OK, ring_bytes[int'(slot) * MAX_BYTES + i],
                                              1'b1, len, (i + 1 == int'(len))));
              end
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // drive one beat, wait for it to be taken, then log its results
  task automatic send_item(op_e op, logic [7:0] d, logic [15:0] cap, bit typed,
                           out_beat_t want);
    if (!calm) begin
      while ($urandom_range(0, 99) < 27) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= {cap, d};
    s_user  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    fresh_beats.delete();
    predict_store(op, d, cap);
    if (typed) begin
      awaited_beats.push_back(want);
    end else begin
      foreach (fresh_beats[i]) awaited_beats.push_back(fresh_beats[i]);
    end
    if (op != OP_NONE) items_done++;
  endtask

  // hold off the sender until every result has come back
  task automatic drain_store();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_beats.size() != 0) @(posedge clk_i);
  endtask

  // compare each result beat against the oldest expectation
  always @(posedge clk_i) begin
    out_beat_t got;
    out_beat_t want;
    if (m_axis_tvalid_o && m_ready) begin
      got.status        = status_e'(m_axis_tuser_o[1:0]);
      got.byte_valid    = m_axis_tuser_o[2];
      got.out_byte      = m_axis_tdata_o[7:0];
      got.packet_length = m_axis_tdata_o[14:8];
      got.queue_count   = m_axis_tdata_o[17:15];
      got.queue_empty   = m_axis_tdata_o[18];
      got.last          = m_axis_tlast_o;
      if (awaited_beats.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat st=%0d byte=%h bv=%b len=%0d last=%b cnt=%0d emp=%b",
                 $time, got.status, got.out_byte, got.byte_valid, got.packet_length,
                 got.last, got.queue_count, got.queue_empty);
      end else begin
        want = awaited_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected st=%0d byte=%h bv=%b len=%0d last=%b cnt=%0d emp=%b",
                   $time, want.status, want.out_byte, want.byte_valid, want.packet_length,
                   want.last, want.queue_count, want.queue_empty);
          $display("%0t: actual   st=%0d byte=%h bv=%b len=%0d last=%b cnt=%0d emp=%b",
                   $time, got.status, got.out_byte, got.byte_valid, got.packet_length,
                   got.last, got.queue_count, got.queue_empty);
        end
      end
    end
  end

  // stimulus
  initial begin
    int        plen;
    int        pick;
    int        sel;
    bit        pressed;
    bit        fill;
    logic [15:0] cap;
    pressed = 1'b0;

    // directed table: empty, zero length, extremes, oversize, full, unused code
    dir_tab.push_back('{OP_DEQUEUE, 8'h00, 16'h0000, 1,  1, STAT_EMPTY,     7'd0,  3'd0});
    dir_tab.push_back('{OP_COMMIT,  8'h00, 16'h0000, 1,  1, STAT_OK,        7'd0,  3'd1});
    dir_tab.push_back('{OP_DEQUEUE, 8'h00, 16'h0000, 1,  1, STAT_OK,        7'd0,  3'd0});
    dir_tab.push_back('{OP_APPEND,  8'h00, 16'hFFFF, 1,  0, STAT_OK,        7'd0,  3'd0});
    dir_tab.push_back('{OP_APPEND,  8'hFF, 16'h0000, 1,  0, STAT_OK,        7'd0,  3'd0});
    dir_tab.push_back('{OP_COMMIT,  8'h00, 16'h0000, 1,  1, STAT_OK,        7'd2,  3'd1});
    dir_tab.push_back('{OP_DEQUEUE, 8'h00, 16'h0001, 1,  1, STAT_TOO_LARGE, 7'd2,  3'd1});
    dir_tab.push_back('{OP_DEQUEUE, 8'hFF, 16'hFFFF, 1,  0, STAT_OK,        7'd0,  3'd0});
    dir_tab.push_back('{OP_APPEND,  8'hA5, 16'h0000, 65, 0, STAT_OK,        7'd0,  3'd0});
    dir_tab.push_back('{OP_COMMIT,  8'h00, 16'h0000, 1,  1, STAT_TOO_LARGE, 7'd64, 3'd0});
    dir_tab.push_back('{OP_APPEND,  8'h3C, 16'h0000, 64, 0, STAT_OK,        7'd0,  3'd0});
    dir_tab.push_back('{OP_COMMIT,  8'h00, 16'h0000, 1,  1, STAT_OK,        7'd64, 3'd1});
    dir_tab.push_back('{OP_DEQUEUE, 8'h00, 16'd63,   1,  1, STAT_TOO_LARGE, 7'd64, 3'd1});
    dir_tab.push_back('{OP_DEQUEUE, 8'h00, 16'd64,   1,  0, STAT_OK,        7'd0,  3'd0});
    dir_tab.push_back('{OP_COMMIT,  8'h00, 16'h0000, 7,  0, STAT_OK,        7'd0,  3'd0});
    dir_tab.push_back('{OP_COMMIT,  8'h00, 16'h0000, 1,  1, STAT_FULL,      7'd0,  3'd7});
    dir_tab.push_back('{OP_APPEND,  8'h5A, 16'h0000, 3,  0, STAT_OK,        7'd0,  3'd0});
    dir_tab.push_back('{OP_COMMIT,  8'h00, 16'h0000, 1,  1, STAT_FULL,      7'd3,  3'd7});
    dir_tab.push_back('{OP_APPEND,  8'h77, 16'h0000, 65, 0, STAT_OK,        7'd0,  3'd0});
    dir_tab.push_back('{OP_COMMIT,  8'h00, 16'h0000, 1,  1, STAT_TOO_LARGE, 7'd64, 3'd7});
    dir_tab.push_back('{OP_NONE,    8'hFF, 16'hFFFF, 1,  0, STAT_OK,        7'd0,  3'd0});
    dir_tab.push_back('{OP_DEQUEUE, 8'h00, 16'h0000, 7,  0, STAT_OK,        7'd0,  3'd0});
    dir_tab.push_back('{OP_DEQUEUE, 8'h00, 16'hFFFF, 1,  1, STAT_EMPTY,     7'd0,  3'd0});

    // reset
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_tab[r]) begin
      for (int k = 0; k < dir_tab[r].reps; k++) begin
        send_item(dir_tab[r].op, dir_tab[r].data + 8'(k), dir_tab[r].cap, dir_tab[r].typed,
                  typed_beat(dir_tab[r].st, dir_tab[r].len, dir_tab[r].cnt));
      end
    end
    drain_store();

    // random packets, alternating fill-heavy and drain-heavy phases
    items_done = 0;
    while (items_done < N_RANDOM) begin
      calm = (items_done >= 50 && items_done < 130);
      if (!pressed && items_done >= 90) begin
        drain_store();
        pressed = 1'b1;
      end
      fill = ((items_done / 40) % 2 == 0);
      pick = $urandom_range(0, 99);
      if (pick < (fill ? 60 : 25)) begin
        // packet: appends then commit, now and then longer than the maximum
        sel = $urandom_range(0, 99);
        if (sel < 70) plen = $urandom_range(0, 8);
        else if (sel < 90) plen = $urandom_range(9, 63);
        else if (sel < 96) plen = MAX_BYTES;
        else plen = $urandom_range(65, 70);
        for (int k = 0; k < plen; k++) begin
          send_item(OP_APPEND, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    1'b0, '0);
        end
        send_item(OP_COMMIT, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  1'b0, '0);
      end else if (pick < 90) begin
        // dequeue, mostly with room to spare
        sel = $urandom_range(0, 99);
        if (sel < 65) cap = 16'($urandom_range(64, 65535));
        else if (sel < 95) cap = 16'($urandom_range(0, 70));
        else cap = 16'd0;
        send_item(OP_DEQUEUE, 8'($urandom_range(0, 255)), cap, 1'b0, '0);
      end else begin
        // noise: stray commit, stray dequeue or unused code
        send_item(op_e'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)), 1'b0, '0);
      end
    end
    calm = 1'b0;

    // wind down: all results back, then let a longest dequeue pass
    drain_store();
    repeat (80) @(posedge clk_i);
    if (awaited_beats.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected beats never arrived", $time, awaited_beats.size());
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== packet_ring_store_top.f =====
sv/prs_pkg.sv
sv/prs_ram.sv
sv/packet_ring_store_top.sv
test/testbench.sv
